FILE: rtl/shader_buffer_layout_packer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the buffer layout packer
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef SHADER_BUFFER_LAYOUT_PACKER_TOP_ASSERT_SVH
`define SHADER_BUFFER_LAYOUT_PACKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SBLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");
// next-cycle implication
`define SBLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");
`else
`define SBLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/sblp_pkg.sv
// ---------------------------------------------------------------------------
// Buffer layout packer package
// Shared constants, layout tables, controller state and command types.
// ---------------------------------------------------------------------------
package sblp_pkg;

	// default store depth
	localparam int MAX_MEMBERS_DEF = 32;

	// stream widths
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;

	// forced alignment armed by a struct-array beat in std140 or std430 mode
	localparam logic [8:0] FORCE_ALIGN = 9'd16;

	// layout modes
	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_STD140  = 2'd1;
	localparam logic [1:0] MODE_STD430  = 2'd2;

	// element types that are never stored
	localparam logic [3:0] TYPE_NONE    = 4'd0;
	localparam logic [3:0] TYPE_INVALID = 4'd15;

	// per-type size and alignment tables
	localparam logic [6:0] SIZE_DEF [16] = '{
		7'd0, 7'd1, 7'd4, 7'd4, 7'd4, 7'd8, 7'd12, 7'd16,
		7'd8, 7'd12, 7'd16, 7'd36, 7'd64, 7'd4, 7'd4, 7'd0};
	localparam logic [6:0] SIZE_STD [16] = '{
		7'd0, 7'd4, 7'd4, 7'd4, 7'd4, 7'd8, 7'd12, 7'd16,
		7'd8, 7'd12, 7'd16, 7'd48, 7'd64, 7'd4, 7'd4, 7'd0};
	localparam logic [4:0] ALGN_DEF [16] = '{
		5'd0, 5'd1, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
		5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd1, 5'd1, 5'd0};
	localparam logic [4:0] ALGN_STD [16] = '{
		5'd0, 5'd4, 5'd4, 5'd4, 5'd4, 5'd8, 5'd16, 5'd16,
		5'd8, 5'd16, 5'd16, 5'd16, 5'd16, 5'd1, 5'd1, 5'd0};

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PLACE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // latch accepted beat
		logic search;  // walk stored ids
		logic place;   // decide and append
		logic emit;    // load output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic search_done;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/sblp_ctrl.sv
// ---------------------------------------------------------------------------
// Buffer layout packer controller
// Sequences accept, id search, placement and result hand-off.
// ---------------------------------------------------------------------------
module sblp_ctrl
	import sblp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_valid,
	input  logic s_func,
	output logic s_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = s_func ? ST_FINISH : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (sts.search_done) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/sblp_dp.sv
// ---------------------------------------------------------------------------
// Buffer layout packer datapath
// Id store, layout state, offset and stride arithmetic, output register.
// ---------------------------------------------------------------------------
`include "shader_buffer_layout_packer_top_assert.svh"

module sblp_dp
	import sblp_pkg::*;
#(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_wr_data,
	input  logic                 in_func,
	input  logic [S_TDATA_W-1:0] in_data,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [M_TDATA_W-1:0] out_data
);

	localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
	localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

	// configuration and layout state
	logic [1:0]       mode_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      end_q;
	logic [4:0]       max_def_q;
	logic [4:0]       max_std_q;
	logic             force_q;

	// latched item
	logic [3:0]  type_q;
	logic [15:0] id_q;
	logic [8:0]  cust_q;

	// search
	logic [15:0]      id_mem [MAX_MEMBERS];
	logic [CNT_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic [15:0]      rd_id_s1;
	logic             dup_q;
	logic             issue;

	// result fields
	logic             acc_q;
	logic [15:0]      off_q;
	logic [6:0]       size_q;
	logic             full_q;

	// output register
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	// placement logic
	logic             is_std;
	logic             bad;
	logic             full;
	logic             ok;
	logic [6:0]       sz;
	logic [4:0]       talign;
	logic [8:0]       a_sel;
	logic [15:0]      a_mask;
	logic [15:0]      off;
	logic [4:0]       balign;
	logic [15:0]      b_mask;
	logic [15:0]      stride;

	assign is_std = (mode_q == MODE_STD140) || (mode_q == MODE_STD430);
	assign issue  = cmd.search && (idx_q < count_q);

	// decide acceptance and offset of the latched push
	always_comb begin
		bad    = (type_q == TYPE_NONE) || (type_q == TYPE_INVALID) || dup_q;
		full   = !bad && (count_q == CNT_W'(MAX_MEMBERS));
		ok     = !bad && !full;
		sz     = is_std ? SIZE_STD[type_q] : SIZE_DEF[type_q];
		talign = is_std ? ALGN_STD[type_q] : ALGN_DEF[type_q];
		a_sel  = cust_q;
		if (force_q && (cust_q < FORCE_ALIGN)) begin
			a_sel = FORCE_ALIGN;
		end
		if (a_sel == 9'd0) begin
			a_sel = {4'd0, talign};
		end
		a_mask = {7'd0, a_sel} - 16'd1;
		if (count_q == '0) begin
			off = 16'd0;
		end else begin
			off = (end_q + a_mask) & ~a_mask;
		end
	end

	// buffer alignment and stride from current state
	always_comb begin
		balign = (count_q == '0) ? 5'd0 : (is_std ? max_std_q : max_def_q);
		b_mask = {11'd0, balign} - 16'd1;
		stride = (balign == 5'd0) ? 16'd0 : ((end_q + b_mask) & ~b_mask);
	end

	// id store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.place && ok) begin
			id_mem[count_q[IDX_W-1:0]] <= id_q;
		end
		rd_id_s1 <= id_mem[idx_q[IDX_W-1:0]];
	end

	// item latch, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= in_data[3:0];
			id_q   <= in_data[19:4];
			cust_q <= in_data[28:20];
		end
	end

	// search walk and duplicate flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			dup_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.load) begin
				idx_q <= '0;
				dup_q <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (rd_vld_s1 && (rd_id_s1 == id_q)) begin
					dup_q <= 1'b1;
				end
			end
		end
	end

	// layout state and per-beat result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_DEFAULT;
			count_q   <= '0;
			end_q     <= '0;
			max_def_q <= '0;
			max_std_q <= '0;
			force_q   <= 1'b0;
			acc_q     <= 1'b0;
			off_q     <= '0;
			size_q    <= '0;
			full_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				acc_q  <= 1'b0;
				off_q  <= '0;
				size_q <= '0;
				full_q <= 1'b0;
				if (in_func && is_std) begin
					force_q <= 1'b1;
				end
			end
			if (cmd.place) begin
				full_q <= full;
				if (ok) begin
					acc_q   <= 1'b1;
					off_q   <= off;
					size_q  <= sz;
					count_q <= count_q + CNT_W'(1);
					end_q   <= off + {9'd0, sz};
					if (ALGN_DEF[type_q] > max_def_q) begin
						max_def_q <= ALGN_DEF[type_q];
					end
					if (ALGN_STD[type_q] > max_std_q) begin
						max_std_q <= ALGN_STD[type_q];
					end
					if (count_q != '0) begin
						force_q <= 1'b0;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {4'd0, full_q, 6'(count_q), stride, balign,
				size_q, off_q, acc_q};
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;
	assign sts.search_done = (idx_q == count_q) && !rd_vld_s1;
	assign sts.out_free    = !out_valid_q || out_ready;

	// checks
	`SBLP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_MEMBERS))
	`SBLP_ASSERT_NXT(a_count_step, clk, arst_n, cmd.place && ok, count_q == $past(count_q) + CNT_W'(1))
	`SBLP_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || out_ready)
	`SBLP_ASSERT_IMP(a_acc_not_full, clk, arst_n, cmd.emit, !(acc_q && full_q))

endmodule

FILE: rtl/shader_buffer_layout_packer_top.sv
// ---------------------------------------------------------------------------
// Shader buffer layout packer
// Appends buffer members and reports their offsets under default, std140
// or std430 layout rules.
// ---------------------------------------------------------------------------
// One input beat gives one output beat. A struct-array beat (tuser high)
// skips the search and placement. A push walks the stored name ids through
// the id memory, one per cycle, to find duplicates; the walk covers every
// member already stored (up to MAX_MEMBERS, 32 at the default depth). Input
// is taken only between beats, but a finished result may wait in the output
// register while the next beat is accepted. A layout_mode write takes effect
// at once, with no recompute pass.
module shader_buffer_layout_packer_top
	import sblp_pkg::*;
#(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// layout_mode register
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_wr_data,
	// input beat
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // elem_type[3:0], name_id[19:4], custom_align[28:20]
	input  logic                 s_tuser,   // func
	// result beat
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // accepted[0], member_offset[16:1],
	                                        // member_size[23:17], buffer_alignment[28:24],
	                                        // stride_bytes[44:29], member_count[50:45],
	                                        // store_full[51]
);

	cmd_t cmd;
	sts_t sts;

	sblp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_func  (s_tuser),
		.s_ready (s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sblp_dp #(
		.MAX_MEMBERS (MAX_MEMBERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_func     (s_tuser),
		.in_data     (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata)
	);

endmodule
